[sv/efpc8_pkg.sv]
// ---------------------------------------------------------------------------
// efpc8_pkg - shared types and constants for the escaped frame packer
// Byte codes, emit phase codes, the held-item record and the CRC-8 step.
// ---------------------------------------------------------------------------
`default_nettype none

package efpc8_pkg;

   localparam logic [7:0] ESC_BYTE     = 8'hFF;
   localparam logic [7:0] SPECIAL_A    = 8'h81;
   localparam logic [7:0] SPECIAL_B    = 8'h88;
   localparam logic [7:0] PAD_BYTE     = 8'h00;
   localparam logic [7:0] CRC_POLY     = 8'h07;
   localparam logic [7:0] CRC_MSB      = 8'h80;
   localparam int         MAX_RESULTS  = 12;
   localparam logic [1:0] HDR_LAST     = 2'd2;
   localparam logic [1:0] HDR_PAYLOAD  = 2'd3;
   localparam logic [5:0] PAY_SAT      = 6'd63;

   // emit phase of the held item
   localparam logic [1:0] PH_DATA = 2'd0;
   localparam logic [1:0] PH_ESC  = 2'd1;
   localparam logic [1:0] PH_CRC  = 2'd2;
   localparam logic [1:0] PH_PAD  = 2'd3;

   typedef struct packed {
      logic [7:0] data;
      logic       esc;
      logic       ends;
      logic       long_flag;
      logic [7:0] crc;
   } item_type;

   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         if ((c & CRC_MSB) != 8'h00) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

[sv/escaped_frame_packer_crc8.sv]
// A byte accepted is first held in the item register, then moves into the output register
// that drives rsp_ once that register is free.
// One input byte per cycle while rsp_stall is low and a byte needs a single result; each
// escape, CRC or pad byte is one more result through the single output byte register.
// Held item: one result per unstalled cycle; req_stall is high until its last result moves.
// Reset (synchronous, active high) clears frame state, the held item and the output register.
// ---------------------------------------------------------------------------
// escaped_frame_packer_crc8 - byte-stuffing framer with CRC-8 and padding
// Passes header, escapes special payload bytes, appends CRC and, for short frames, zero padding.
// ---------------------------------------------------------------------------
`default_nettype none

module escaped_frame_packer_crc8 #(
   parameter int MIN_FRAME_BYTES   = 14,
   parameter int MAX_PAYLOAD_BYTES = 31
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_in_last,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_frame_end,
   output logic            rsp_too_long
);
   import efpc8_pkg::*;

   // frame state
   logic [1:0] hdr_pos_ff, hdr_pos_in;
   logic [7:0] crc_ff, crc_in;
   logic [5:0] pay_cnt_ff, pay_cnt_in;
   logic [3:0] emit_cnt_ff, emit_cnt_in;

   // held item
   logic       item_valid_ff, item_valid_in;
   item_type   item_ff, item_in;
   logic [1:0] phase_ff, phase_in;
   logic [3:0] res_cnt_ff, res_cnt_in;

   // output register
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       out_end_ff, out_end_in;
   logic       out_long_ff, out_long_in;

   logic       accept, advance, item_final, out_free;
   logic [7:0] res_byte;
   logic       res_end;
   logic [1:0] next_phase;
   logic       is_payload, ends, special;
   logic [5:0] pay_next;
   logic [4:0] emit_plus;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = item_valid_ff && out_free;
   assign req_stall = item_valid_ff && !(advance && item_final);
   assign accept    = req_valid && !req_stall;

   assign emit_plus = {1'b0, emit_cnt_ff} + 5'd1;

   // result of the held item for its current phase
   always_comb begin
      res_byte   = item_ff.data;
      res_end    = 1'b0;
      item_final = 1'b0;
      next_phase = phase_ff;
      case (phase_ff)
         PH_DATA: begin
            res_byte = item_ff.data;
            if (item_ff.esc) begin
               next_phase = PH_ESC;
            end else if (item_ff.ends) begin
               next_phase = PH_CRC;
            end else begin
               item_final = 1'b1;
            end
         end
         PH_ESC: begin
            res_byte = ESC_BYTE;
            if (item_ff.ends) begin
               next_phase = PH_CRC;
            end else begin
               item_final = 1'b1;
            end
         end
         PH_CRC: begin
            res_byte = item_ff.crc;
            if (emit_plus < 5'(MIN_FRAME_BYTES)) begin
               next_phase = PH_PAD;
            end else begin
               res_end    = 1'b1;
               item_final = 1'b1;
            end
         end
         PH_PAD: begin
            res_byte = PAD_BYTE;
            if (emit_plus >= 5'(MIN_FRAME_BYTES) ||
                res_cnt_ff >= 4'(MAX_RESULTS - 1)) begin
               res_end    = 1'b1;
               item_final = 1'b1;
            end
         end
         default: begin
            item_final = 1'b1;
         end
      endcase
   end

   // frame state update at input transfer
   always_comb begin
      is_payload = (hdr_pos_ff == HDR_PAYLOAD);
      special    = (req_in_byte == SPECIAL_A) || (req_in_byte == SPECIAL_B) ||
                   (req_in_byte == ESC_BYTE);
      pay_next   = (is_payload && pay_cnt_ff < PAY_SAT) ? pay_cnt_ff + 6'd1 : pay_cnt_ff;
      ends       = is_payload ? req_in_last : (req_in_last && hdr_pos_ff == HDR_LAST);

      item_in.data      = req_in_byte;
      item_in.esc       = is_payload && special;
      item_in.ends      = ends;
      item_in.long_flag = pay_next > 6'(MAX_PAYLOAD_BYTES);
      item_in.crc       = crc8_byte(crc_ff, req_in_byte);

      hdr_pos_in = hdr_pos_ff;
      crc_in     = crc_ff;
      pay_cnt_in = pay_cnt_ff;
      if (accept) begin
         if (ends) begin
            hdr_pos_in = 2'd0;
            crc_in     = 8'h00;
            pay_cnt_in = 6'd0;
         end else begin
            hdr_pos_in = is_payload ? HDR_PAYLOAD : hdr_pos_ff + 2'd1;
            crc_in     = item_in.crc;
            pay_cnt_in = pay_next;
         end
      end
   end

   always_comb begin
      item_valid_in = item_valid_ff;
      phase_in      = phase_ff;
      res_cnt_in    = res_cnt_ff;
      if (advance) begin
         phase_in   = next_phase;
         res_cnt_in = res_cnt_ff + 4'd1;
         if (item_final) begin
            item_valid_in = 1'b0;
         end
      end
      if (accept) begin
         item_valid_in = 1'b1;
         phase_in      = PH_DATA;
         res_cnt_in    = 4'd0;
      end
   end

   always_comb begin
      emit_cnt_in = emit_cnt_ff;
      if (advance) begin
         if (res_end) begin
            emit_cnt_in = 4'd0;
         end else if (emit_plus <= 5'(MIN_FRAME_BYTES)) begin
            emit_cnt_in = emit_plus[3:0];
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && rsp_stall;
      out_byte_in  = out_byte_ff;
      out_end_in   = out_end_ff;
      out_long_in  = out_long_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_byte_in  = res_byte;
         out_end_in   = res_end;
         out_long_in  = item_ff.long_flag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_pos_ff    <= 2'd0;
         crc_ff        <= 8'h00;
         pay_cnt_ff    <= 6'd0;
         emit_cnt_ff   <= 4'd0;
         item_valid_ff <= 1'b0;
         phase_ff      <= PH_DATA;
         res_cnt_ff    <= 4'd0;
         out_valid_ff  <= 1'b0;
      end else begin
         hdr_pos_ff    <= hdr_pos_in;
         crc_ff        <= crc_in;
         pay_cnt_ff    <= pay_cnt_in;
         emit_cnt_ff   <= emit_cnt_in;
         item_valid_ff <= item_valid_in;
         phase_ff      <= phase_in;
         res_cnt_ff    <= res_cnt_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
      out_byte_ff <= out_byte_in;
      out_end_ff  <= out_end_in;
      out_long_ff <= out_long_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_out_byte  = out_byte_ff;
   assign rsp_frame_end = out_end_ff;
   assign rsp_too_long  = out_long_ff;

endmodule

`default_nettype wire

[sv/efpc8_checker.sv]
// ---------------------------------------------------------------------------
// efpc8_checker - port-level checks for the escaped frame packer
// Watches reset, output hold under stall, input stall draining and the
// too_long flag over a frame.
// ---------------------------------------------------------------------------
`default_nettype none

module efpc8_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_frame_end,
   input wire logic       rsp_too_long
);

   // nothing in flight right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("output or stall active after reset");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_out_byte) &&
                                    $stable(rsp_frame_end)))
      else $error("stalled result changed");

   // too_long stays up through the rest of the frame
   a_long_sticky: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_too_long && !rsp_frame_end) |=>
         (!rsp_valid || rsp_too_long))
      else $error("too_long dropped inside a frame");

   // a new frame starts with too_long clear
   a_long_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_frame_end) |=> (!rsp_valid || !rsp_too_long))
      else $error("too_long set on first byte of a frame");

   // a held item moves into an empty output register at once
   a_stall_drains: assert property (@(posedge clock) disable iff (reset)
      (req_stall && !rsp_valid) |=> rsp_valid)
      else $error("input stalled with nothing moving out");

endmodule

bind escaped_frame_packer_crc8 efpc8_checker u_efpc8_checker (
   .clock         (clock),
   .reset         (reset),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_out_byte  (rsp_out_byte),
   .rsp_frame_end (rsp_frame_end),
   .rsp_too_long  (rsp_too_long)
);

`default_nettype wire
